// ----- rtl/cawss_pkg.sv -----
package cawss_pkg;

    // Longest pattern the window compares against
    localparam int MaxPattern  = 16;
    // Pattern characters held by the two 64-bit pattern registers
    localparam int PatRegChars = 16;

    localparam int LenW    = $clog2(MaxPattern + 1);
    localparam int FillW   = $clog2(MaxPattern + 2);
    localparam int PatIdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int PatLenW  = 5;
    localparam int LineW    = 32;

    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int QCntW  = 3;

    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChCr        = 8'h0D;
    localparam logic [7:0] ChSlash     = 8'h2F;
    localparam logic [7:0] ChStar      = 8'h2A;
    localparam logic [7:0] ChDquote    = 8'h22;
    localparam logic [7:0] ChSquote    = 8'h27;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChUnderscore = 8'h5F;

    typedef enum logic [CfgIdxW-1:0] {
        CfgPatLow       = 3'd0,
        CfgPatHigh      = 3'd1,
        CfgPatLen       = 3'd2,
        CfgWholeWord    = 3'd3,
        CfgSkipComments = 3'd4
    } t_cfg_idx;

    typedef logic [MaxPattern-1:0][7:0] t_pat;
    typedef logic [MaxPattern:0][7:0]   t_win;

    // One classified input byte: up to two kept bytes, in order, plus line end and file end
    typedef struct packed {
        logic       k0_vld;
        logic [7:0] k0_byte;
        logic       k1_vld;
        logic [7:0] k1_byte;
        logic       line_end;
        logic       file_end;
    } t_cmd;

    typedef struct packed {
        logic [CfgDataW-1:0] pat_low;
        logic [CfgDataW-1:0] pat_high;
        logic [PatLenW-1:0]  pat_len;
        logic                whole_word;
        logic                skip_comments;
    } t_cfg;

    typedef struct packed {
        t_win             win;
        logic [FillW-1:0] fill;
        logic             tail;
        logic             found;
    } t_match;

    function automatic logic is_word_byte(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || (c == ChUnderscore);
    endfunction

    // Shift one kept byte into the window and check the aligned pattern.
    // pal[j] is the pattern character expected at window position j.
    function automatic t_match keep_step(input t_match s, input logic [7:0] c,
                                         input t_pat pal, input logic [LenW-1:0] n,
                                         input logic whole_word);
        t_match r;
        logic   hit;
        r = s;
        if (s.tail) begin
            r.tail = 1'b0;
            if (!is_word_byte(c)) begin
                r.found = 1'b1;
            end
        end
        for (int j = MaxPattern; j > 0; j--) begin
            r.win[j] = s.win[j-1];
        end
        r.win[0] = c;
        if (s.fill != FillW'(MaxPattern + 1)) begin
            r.fill = s.fill + 1'b1;
        end
        hit = (r.fill >= FillW'(n));
        for (int j = 0; j < MaxPattern; j++) begin
            if ((j < int'(n)) && (r.win[j] != pal[j])) begin
                hit = 1'b0;
            end
        end
        if (hit) begin
            if (!whole_word) begin
                r.found = 1'b1;
            end else if ((r.fill == FillW'(n)) || !is_word_byte(r.win[n])) begin
                r.tail = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/cawss_front.sv -----
module cawss_front
    import cawss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_file_end,
    input  logic       i_skip_comments,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic r_in_block, n_in_block;
    logic r_in_lit,   n_in_lit;
    logic r_held,     n_held;
    logic r_prev_star, n_prev_star;
    logic r_prev_bs,  n_prev_bs;
    logic r_skip_rest, n_skip_rest;
    logic accept;
    t_cmd cmd;

    function automatic t_cmd add_keep(input t_cmd c, input logic [7:0] b);
        t_cmd r;
        r = c;
        if (!c.k0_vld) begin
            r.k0_vld  = 1'b1;
            r.k0_byte = b;
        end else begin
            r.k1_vld  = 1'b1;
            r.k1_byte = b;
        end
        return r;
    endfunction

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        logic done;
        logic line_end;
        n_in_block  = r_in_block;
        n_in_lit    = r_in_lit;
        n_held      = r_held;
        n_prev_star = r_prev_star;
        n_prev_bs   = r_prev_bs;
        n_skip_rest = r_skip_rest;
        cmd         = '0;
        done        = 1'b0;
        line_end    = (i_text_byte == ChNewline) || i_file_end;

        if (i_text_byte != ChNewline) begin
            if (i_skip_comments) begin
                n_prev_bs = (i_text_byte == ChBackslash);
                if (r_skip_rest) begin
                    done = 1'b1;
                end else if (r_in_block) begin
                    if (r_prev_star && i_text_byte == ChSlash) begin
                        n_in_block  = 1'b0;
                        n_prev_star = 1'b0;
                    end else begin
                        n_prev_star = (i_text_byte == ChStar);
                    end
                end else begin
                    n_held = 1'b0;
                    if (r_held) begin
                        if (i_text_byte == ChSlash) begin
                            n_skip_rest = 1'b1;
                            done = 1'b1;
                        end else if (i_text_byte == ChStar) begin
                            n_in_block  = 1'b1;
                            n_prev_star = 1'b0;
                            done = 1'b1;
                        end else begin
                            cmd = add_keep(cmd, ChSlash);
                        end
                    end
                    if (!done) begin
                        if (i_text_byte == ChCr) begin
                            n_skip_rest = 1'b1;
                        end else if (!r_in_lit && i_text_byte == ChSlash) begin
                            n_held = 1'b1;
                        end else begin
                            if ((i_text_byte inside {ChDquote, ChSquote}) && !r_prev_bs) begin
                                n_in_lit = !r_in_lit;
                            end
                            cmd = add_keep(cmd, i_text_byte);
                        end
                    end
                end
            end else begin
                cmd = add_keep(cmd, i_text_byte);
            end
        end

        if (line_end) begin
            if (n_held) begin
                cmd = add_keep(cmd, ChSlash);
            end
            n_in_lit    = 1'b0;
            n_held      = 1'b0;
            n_prev_star = 1'b0;
            n_prev_bs   = 1'b0;
            n_skip_rest = 1'b0;
            if (i_file_end) begin
                n_in_block = 1'b0;
            end
        end
        cmd.line_end = line_end;
        cmd.file_end = i_file_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_block  <= 1'b0;
            r_in_lit    <= 1'b0;
            r_held      <= 1'b0;
            r_prev_star <= 1'b0;
            r_prev_bs   <= 1'b0;
            r_skip_rest <= 1'b0;
        end else if (accept) begin
            r_in_block  <= n_in_block;
            r_in_lit    <= n_in_lit;
            r_held      <= n_held;
            r_prev_star <= n_prev_star;
            r_prev_bs   <= n_prev_bs;
            r_skip_rest <= n_skip_rest;
        end
    end

    // Drop bytes that neither keep anything nor end a line
    assign o_push = accept && (cmd.k0_vld || cmd.line_end);
    assign o_cmd  = cmd;

endmodule

// ----- rtl/cawss_queue.sv -----
module cawss_queue
    import cawss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_vld,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_cnt;

    assign o_full = (r_cnt == QCntW'(QDepth));
    assign o_vld  = (r_cnt != '0);
    assign o_cmd  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/cawss_back.sv -----
module cawss_back
    import cawss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_cmd_vld,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [LineW-1:0] o_line_number,
    output logic             o_line_matched
);

    t_match            r_st, n_st;
    logic [LineW-1:0]  r_line, n_line;
    logic              r_out_valid;
    logic [LineW-1:0]  r_out_line;
    logic              r_out_matched;
    logic [LenW-1:0]   eff_len;
    t_pat              pat;
    t_pat              pal;
    t_match            st1, st2;
    logic              out_free;

    always_comb begin
        if (i_cfg.pat_len == '0) begin
            eff_len = LenW'(1);
        end else if (int'(i_cfg.pat_len) > MaxPattern) begin
            eff_len = LenW'(MaxPattern);
        end else begin
            eff_len = LenW'(i_cfg.pat_len);
        end
    end

    always_comb begin
        logic [2*CfgDataW-1:0] pat_all;
        pat_all = {i_cfg.pat_high, i_cfg.pat_low};
        for (int k = 0; k < MaxPattern; k++) begin
            pat[k] = (k < PatRegChars) ? pat_all[8*(k % PatRegChars) +: 8] : 8'h00;
        end
    end

    // Align the pattern so its last character sits at window position 0
    always_comb begin
        logic [LenW-1:0] idx;
        for (int j = 0; j < MaxPattern; j++) begin
            idx    = eff_len - LenW'(j + 1);
            pal[j] = (j < int'(eff_len)) ? pat[idx[PatIdxW-1:0]] : 8'h00;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_cmd_vld && (!i_cmd.line_end || out_free);

    always_comb begin
        st1 = i_cmd.k0_vld ? keep_step(r_st, i_cmd.k0_byte, pal, eff_len, i_cfg.whole_word)
                           : r_st;
        st2 = i_cmd.k1_vld ? keep_step(st1, i_cmd.k1_byte, pal, eff_len, i_cfg.whole_word)
                           : st1;
        n_st   = st2;
        n_line = r_line;
        if (i_cmd.line_end) begin
            n_st = '0;
            if (i_cmd.file_end) begin
                n_line = LineW'(1);
            end else if (r_line != '1) begin
                n_line = r_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_line      <= LineW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_st   <= n_st;
                r_line <= n_line;
            end
            if (o_pop && i_cmd.line_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.line_end) begin
            r_out_line    <= r_line;
            r_out_matched <= st2.found || st2.tail;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_number  = r_out_line;
    assign o_line_matched = r_out_matched;

endmodule

// ----- rtl/comment_aware_word_search.sv -----
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ---------------------------------
// in        input      i_in_valid / o_in_stall   i_text_byte, i_file_end
// out       output     o_out_valid / i_out_stall o_line_number, o_line_matched
// cfg       input      i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One input byte is taken per cycle while o_in_stall is low; a finished line passes
// through the command queue and the matcher and is presented from the out register.
// A four-entry command queue between the comment filter and the window matcher sets
// the slack: input stalls only when four classified bytes wait behind a stalled output
// register. Reset is synchronous, active low, clears the state flags, sets the line
// counter and the pattern length to 1 and turns comment skipping on.
module comment_aware_word_search
    import cawss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_text_byte,
    input  logic                i_file_end,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [LineW-1:0]    o_line_number,
    output logic                o_line_matched,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_full;
    logic q_vld;
    t_cmd q_out_cmd;
    logic q_pop;

    // Configuration registers: the user must write them only while the block holds no transaction; not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_low       <= '0;
            r_cfg.pat_high      <= '0;
            r_cfg.pat_len       <= PatLenW'(1);
            r_cfg.whole_word    <= 1'b0;
            r_cfg.skip_comments <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgPatLow: begin
                    r_cfg.pat_low <= i_cfg_data;
                end
                CfgPatHigh: begin
                    r_cfg.pat_high <= i_cfg_data;
                end
                CfgPatLen: begin
                    r_cfg.pat_len <= i_cfg_data[PatLenW-1:0];
                end
                CfgWholeWord: begin
                    r_cfg.whole_word <= i_cfg_data[0];
                end
                CfgSkipComments: begin
                    r_cfg.skip_comments <= i_cfg_data[0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Front: strip comments when enabled and classify each byte into kept bytes and line end
    cawss_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_byte     (i_text_byte),
        .i_file_end      (i_file_end),
        .i_skip_comments (r_cfg.skip_comments),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_cmd           (q_in_cmd)
    );

    // Queue: decouple the filter from the matcher so each can stall on its own
    cawss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    // Back: shift kept bytes through the window, match, and report each line
    cawss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_vld      (q_vld),
        .i_cmd          (q_out_cmd),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_line_number  (o_line_number),
        .o_line_matched (o_line_matched)
    );

endmodule
